// ----- rtl/bounded_doubly_linked_list_engine_macros.svh -----
// assertion macros for the linked list engine checker
// no dependencies
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ----- rtl/bdll_pkg.sv -----
// shared types and constants for the linked list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bdll_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0, CMD_INS_TAIL = 3'd1, CMD_INS_POS = 3'd2, CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4, CMD_DEL_POS = 3'd5, CMD_FWD_READ = 3'd6, CMD_BACK_READ = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_BADPOS = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_INS_A, S_INS_B, S_DEL_A, S_DEL_B, S_READ, S_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/bdll_mem.sv -----
// node memory: value, next and prev links, one synchronous read port
// depends on bdll_pkg
`timescale 1ns / 1ps
`default_nettype none
module bdll_mem #(
  parameter int CAPACITY = 16,
  parameter int DATA_WIDTH = 32,
  localparam int SW = $clog2(CAPACITY)
) (
  input  wire logic                  clk,
  input  wire logic [SW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0]      rvalue,
  output logic [SW-1:0]              rnext,
  output logic [SW-1:0]              rprev,
  input  wire logic                  we_v,
  input  wire logic [SW-1:0]         waddr_v,
  input  wire logic [DATA_WIDTH-1:0] wvalue,
  input  wire logic                  we_n,
  input  wire logic [SW-1:0]         waddr_n,
  input  wire logic [SW-1:0]         wnext,
  input  wire logic                  we_p,
  input  wire logic [SW-1:0]         waddr_p,
  input  wire logic [SW-1:0]         wprev
);
  import bdll_pkg::*;
  logic [DATA_WIDTH-1:0] vmem [CAPACITY];
  logic [SW-1:0] nmem [CAPACITY];
  logic [SW-1:0] pmem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we_v) vmem[waddr_v] <= wvalue;
    if (we_n) nmem[waddr_n] <= wnext;
    if (we_p) pmem[waddr_p] <= wprev;
    rvalue <= vmem[raddr];
    rnext <= nmem[raddr];
    rprev <= pmem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/bdll_free.sv -----
// free slot stack, top at CAPACITY - count - 1, pushes go to CAPACITY - count
// depends on bdll_pkg
`timescale 1ns / 1ps
`default_nettype none
module bdll_free #(
  parameter int CAPACITY = 16,
  localparam int SW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [CW-1:0] count,
  output logic [SW-1:0]      top_slot,
  input  wire logic          push,
  input  wire logic [SW-1:0] push_slot
);
  import bdll_pkg::*;
  logic [SW-1:0] stack [CAPACITY];
  logic [CW-1:0] pop_idx, push_idx;
  assign pop_idx = CW'(CAPACITY) - count - CW'(1);
  assign push_idx = CW'(CAPACITY) - count;
  assign top_slot = stack[pop_idx[SW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) stack[i] <= SW'(i);
    end else if (push) begin
      stack[push_idx[SW-1:0]] <= push_slot;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bounded_doubly_linked_list_engine.sv -----
// Linked list engine: an ordered list of up to CAPACITY values kept as a circular
// doubly linked list in a node memory with one registered read port, plus a free
// slot stack. One command at a time. Tail and positional commands walk the links from
// the head one node at a time, waiting on each memory read; reads emit one element at a
// time, each held until the output handshake. Results go out through one output register.
// depends on bdll_pkg, bdll_mem, bdll_free
`timescale 1ns / 1ps
`default_nettype none
module bounded_doubly_linked_list_engine #(
  parameter int CAPACITY = bdll_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdll_pkg::DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [31:0]      element,
  output logic                    element_valid,
  output logic [4:0]              length,
  output logic                    last
);
  import bdll_pkg::*;
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next, after_walk;
  logic [2:0] op;
  logic [7:0] pos_r;
  logic [DATA_WIDTH-1:0] val;
  logic [CW-1:0] count, steps, idx;
  logic [SW-1:0] head, cur, slot, pred;
  logic pend;

  logic [SW-1:0] raddr, rnext, rprev;
  logic [DATA_WIDTH-1:0] rvalue;
  logic we_v, we_n, we_p, push;
  logic [SW-1:0] wa_n, wa_p, wd_n, wd_p, top_slot;

  bdll_mem #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_mem (
    .clk, .raddr, .rvalue, .rnext, .rprev,
    .we_v, .waddr_v(slot), .wvalue(val),
    .we_n, .waddr_n(wa_n), .wnext(wd_n),
    .we_p, .waddr_p(wa_p), .wprev(wd_p)
  );
  bdll_free #(.CAPACITY(CAPACITY)) u_free (
    .clk, .rst, .count, .top_slot, .push, .push_slot(cur)
  );

  logic [8:0] pos9, cnt9;
  logic [CW-1:0] pos_c;
  assign pos9 = {1'b0, position};
  assign cnt9 = 9'(count);
  assign pos_c = CW'(position);
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign raddr = cur;
  assign push = (state == S_DEL_B);

  // memory writes
  always_comb begin
    we_v = 1'b0; we_n = 1'b0; we_p = 1'b0;
    wa_n = slot; wa_p = slot; wd_n = slot; wd_p = slot;
    unique case (state)
      S_INS_A: begin
        we_v = 1'b1; we_n = 1'b1; we_p = 1'b1;
        if (count != '0) begin
          wd_n = cur; wd_p = rprev;
        end
      end
      S_INS_B: begin
        if (count != '0) begin
          we_n = 1'b1; wa_n = pred; wd_n = slot;
          we_p = 1'b1; wa_p = cur; wd_p = slot;
        end
      end
      S_DEL_A: begin
        if (count != CW'(1)) begin
          we_n = 1'b1; wa_n = rprev; wd_n = rnext;
          we_p = 1'b1; wa_p = rnext; wd_p = rprev;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; count <= '0; head <= '0; pend <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= cmd; val <= DATA_WIDTH'(value); cur <= head; pos_r <= position;
          element <= '0; element_valid <= 1'b0; last <= 1'b1;
          idx <= '0; pend <= 1'b1;
          unique case (cmd_t'(cmd))
            CMD_INS_HEAD: steps <= '0;
            CMD_INS_TAIL: steps <= count;
            CMD_INS_POS: steps <= pos_c - CW'(1);
            CMD_DEL_HEAD: steps <= '0;
            CMD_DEL_TAIL: steps <= count - CW'(1);
            CMD_DEL_POS: steps <= pos_c - CW'(1);
            default: steps <= '0;
          endcase
          slot <= top_slot;
        end
        S_WALK: if (pend) pend <= 1'b0;
          else if (steps != '0) begin
            cur <= rnext; steps <= steps - CW'(1); pend <= 1'b1;
          end
        S_INS_A: begin
          pred <= rprev;
          if (count == '0 || op == CMD_INS_HEAD || (op == CMD_INS_POS && pos_r == 8'd1))
            head <= slot;
        end
        S_INS_B: begin
          count <= count + CW'(1); length <= 5'(count + CW'(1)); out_valid <= 1'b1;
        end
        S_DEL_A: begin
          if (count == CW'(1)) head <= '0;
          else if (op == CMD_DEL_HEAD || (op == CMD_DEL_POS && pos_r == 8'd1))
            head <= rnext;
        end
        S_DEL_B: begin
          count <= count - CW'(1); length <= 5'(count - CW'(1)); out_valid <= 1'b1;
        end
        S_READ: if (pend) pend <= 1'b0;
          else if (!out_valid) begin
            if (op == CMD_BACK_READ && idx == '0 && steps == '0) begin
              cur <= rprev; steps <= CW'(1); pend <= 1'b1;
            end else begin
              element <= 32'(signed'(rvalue)); element_valid <= 1'b1;
              length <= 5'(count); last <= (idx + CW'(1) == count);
              out_valid <= 1'b1; idx <= idx + CW'(1);
              cur <= (op == CMD_BACK_READ) ? rprev : rnext; pend <= 1'b1;
            end
          end
        S_EMIT: begin
          length <= 5'(count); out_valid <= 1'b1;
        end
        default: ;
      endcase
      if (state == S_IDLE && in_valid && in_ready) begin
        unique case (cmd_t'(cmd))
          CMD_INS_HEAD, CMD_INS_TAIL:
            status <= (count == CW'(CAPACITY)) ? ST_FULL : ST_OK;
          CMD_INS_POS:
            if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) status <= ST_BADPOS;
            else if (count == CW'(CAPACITY)) status <= ST_FULL;
            else status <= ST_OK;
          CMD_DEL_HEAD, CMD_DEL_TAIL:
            status <= (count == '0) ? ST_EMPTY : ST_OK;
          CMD_DEL_POS:
            if (count == '0) status <= ST_EMPTY;
            else if (pos9 == 9'd0 || pos9 > cnt9) status <= ST_BADPOS;
            else status <= ST_OK;
          default:
            status <= (count == '0) ? ST_EMPTY : ST_OK;
        endcase
        after_walk <= (cmd_t'(cmd) <= CMD_INS_POS) ? S_INS_A : S_DEL_A;
      end
    end
  end

  logic bad;
  always_comb begin
    state_next = state;
    bad = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_INS_HEAD, CMD_INS_TAIL: bad = (count == CW'(CAPACITY));
      CMD_INS_POS: bad = (pos9 == 9'd0 || pos9 > cnt9 + 9'd1 || count == CW'(CAPACITY));
      CMD_DEL_HEAD, CMD_DEL_TAIL: bad = (count == '0);
      CMD_DEL_POS: bad = (count == '0 || pos9 == 9'd0 || pos9 > cnt9);
      default: bad = (count == '0);
    endcase
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (bad) state_next = S_EMIT;
        else if (cmd == CMD_FWD_READ || cmd == CMD_BACK_READ) state_next = S_READ;
        else if (cmd_t'(cmd) <= CMD_INS_POS && count == '0) state_next = S_INS_A;
        else state_next = S_WALK;
      end
      S_WALK: if (!pend && steps == '0) state_next = after_walk;
      S_INS_A: state_next = S_INS_B;
      S_INS_B: state_next = S_IDLE;
      S_DEL_A: state_next = S_DEL_B;
      S_DEL_B: state_next = S_IDLE;
      S_READ: if (!pend && !out_valid && !(op == CMD_BACK_READ && idx == '0 && steps == '0)
                  && idx + CW'(1) == count) state_next = S_IDLE;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/bdll_checker.sv -----
// port-level checker for the linked list engine, bound to the top level
// depends on bdll_pkg and bounded_doubly_linked_list_engine_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_doubly_linked_list_engine_macros.svh"
module bdll_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic       element_valid,
  input wire logic [4:0] length,
  input wire logic       last
);
  import bdll_pkg::*;
  `CHK_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `CHK_IMPL(no_accept_busy, clk, rst, out_valid, !in_ready)
  `CHK_IMPL(elem_ok, clk, rst, out_valid && element_valid, status == ST_OK)
  `CHK_IMPL(len_range, clk, rst, out_valid, length <= 5'd16)
  `CHK_IMPL(fail_last, clk, rst, out_valid && !element_valid, last)
endmodule
bind bounded_doubly_linked_list_engine bdll_checker u_chk (.*);
`default_nettype wire

// ----- tb/tb_list_checker.sv -----
// checker for the linked list engine: watches both channels, keeps its own list
// of values in order, predicts every result and compares field by field
// depends on bdll_pkg
`timescale 1ns / 1ps
module tb_list_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic signed [31:0] element,
  input  logic               element_valid,
  input  logic [4:0]         length,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);
  import bdll_pkg::*;

  typedef struct packed {
    status_t            st;
    logic signed [31:0] elem;
    logic               elem_vld;
    logic [4:0]         len;
    logic               lst;
  } list_result_t;

  logic signed [31:0] list_vals[$];
  list_result_t       expected_results[$];

  assign pending = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic push_status(input status_t s);
    expected_results.push_back('{s, 32'sd0, 1'b0, 5'(list_vals.size()), 1'b1});
  endtask

  task automatic predict_list(input cmd_t c, input logic signed [31:0] v, input int p);
    int n;
    n = list_vals.size();
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (c == CMD_INS_POS && (p < 1 || p > n + 1)) push_status(ST_BADPOS);
        else if (n >= CAPACITY) push_status(ST_FULL);
        else begin
          if (c == CMD_INS_HEAD) list_vals.push_front(v);
          else if (c == CMD_INS_TAIL) list_vals.push_back(v);
          else list_vals.insert(p - 1, v);
          push_status(ST_OK);
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
        if (n == 0) push_status(ST_EMPTY);
        else if (c == CMD_DEL_POS && (p < 1 || p > n)) push_status(ST_BADPOS);
        else begin
          if (c == CMD_DEL_HEAD) list_vals.delete(0);
          else if (c == CMD_DEL_TAIL) list_vals.delete(n - 1);
          else list_vals.delete(p - 1);
          push_status(ST_OK);
        end
      end
      default: begin
        if (n == 0) push_status(ST_EMPTY);
        else
          for (int i = 0; i < n; i++)
            expected_results.push_back('{ST_OK,
              (c == CMD_FWD_READ) ? list_vals[i] : list_vals[n - 1 - i],
              1'b1, 5'(n), 1'(i == n - 1)});
      end
    endcase
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    list_result_t e;
    if (!rst) begin
      if (in_valid && in_ready) predict_list(cmd_t'(cmd), value, position);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) report_mismatch("result with none expected");
        else begin
          e = expected_results.pop_front();
          if (status !== e.st) report_mismatch($sformatf("status %0d exp %0d", status, e.st));
          if (element !== e.elem)
            report_mismatch($sformatf("element %0d exp %0d", element, e.elem));
          if (element_valid !== e.elem_vld) report_mismatch("element_valid");
          if (length !== e.len) report_mismatch($sformatf("length %0d exp %0d", length, e.len));
          if (last !== e.lst) report_mismatch("last");
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// top of the linked list engine testbench: clock, reset, request stimulus and verdict
// depends on bdll_pkg, bounded_doubly_linked_list_engine, tb_list_checker
`timescale 1ns / 1ps
module tb_top;
  import bdll_pkg::*;

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] cmd;
  logic signed [31:0] value, element;
  logic [7:0] position;
  logic [1:0] status;
  logic element_valid, last;
  logic [4:0] length;
  int fail_count, pending, cycles;
  int model_len;

  bounded_doubly_linked_list_engine #(.CAPACITY(CAP)) i_dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .value, .position,
    .out_valid, .out_ready, .status, .element, .element_valid, .length, .last
  );

  tb_list_checker #(.CAPACITY(CAP)) i_checker (
    .clk, .rst, .in_valid, .in_ready, .cmd, .value, .position,
    .out_valid, .out_ready, .status, .element, .element_valid, .length, .last,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver drops out_ready for a random stall before taking each result, with calm stretches
  initial begin
    int w;
    out_ready = 0;
    @(negedge clk);
    forever begin
      w = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(input cmd_t c, input logic signed [31:0] v, input int p);
    int w;
    w = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    value <= v;
    position <= 8'(p);
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    // track length so random positions mostly land in range
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL: if (model_len < CAP) model_len++;
      CMD_INS_POS: if (p >= 1 && p <= model_len + 1 && model_len < CAP) model_len++;
      CMD_DEL_HEAD, CMD_DEL_TAIL: if (model_len > 0) model_len--;
      CMD_DEL_POS: if (model_len > 0 && p >= 1 && p <= model_len) model_len--;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_t c;
    int p, r;
    rst = 1;
    in_valid = 0;
    cmd = CMD_INS_HEAD;
    value = 0;
    position = 0;
    cycles = 0;
    model_len = 0;
    repeat (6) @(negedge clk);
    rst = 0;
    // empty list cases, then inserts, reads and deletes at the ends and in the middle
    send_request(CMD_FWD_READ, 0, 0);
    send_request(CMD_BACK_READ, 0, 0);
    send_request(CMD_DEL_HEAD, 0, 0);
    send_request(CMD_DEL_TAIL, 0, 0);
    send_request(CMD_DEL_POS, 0, 0);
    send_request(CMD_INS_POS, 5, 0);
    send_request(CMD_INS_POS, 5, 2);
    send_request(CMD_INS_POS, 32'sh7fffffff, 1);
    send_request(CMD_INS_HEAD, 32'sh80000000, 0);
    send_request(CMD_INS_TAIL, -1, 255);
    send_request(CMD_INS_POS, 32'sh55aa55aa, 4);
    send_request(CMD_INS_POS, 32'sh2aa55aa5, 2);
    send_request(CMD_FWD_READ, 0, 0);
    send_request(CMD_BACK_READ, 0, 0);
    send_request(CMD_DEL_POS, 0, 0);
    send_request(CMD_DEL_POS, 0, 6);
    send_request(CMD_DEL_POS, 0, 3);
    send_request(CMD_DEL_TAIL, 0, 0);
    send_request(CMD_DEL_HEAD, 0, 0);
    send_request(CMD_DEL_POS, 0, 2);
    send_request(CMD_DEL_POS, 0, 1);
    send_request(CMD_FWD_READ, 0, 0);
    // fill to capacity and overflow, then read both ways
    for (int i = 0; i < CAP + 2; i++) send_request(cmd_t'(i % 3), rand_value(), 1);
    send_request(CMD_INS_POS, 0, 17);
    send_request(CMD_FWD_READ, 0, 0);
    send_request(CMD_BACK_READ, 0, 0);
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      // drift toward growth or shrink in long swings
      if (r < 45) c = cmd_t'($urandom_range(0, 2));
      else if (r < 85) c = cmd_t'($urandom_range(3, 5));
      else c = cmd_t'($urandom_range(6, 7));
      if ((i / 40) % 2 == 1 && c <= CMD_INS_POS && $urandom_range(0, 1)) c = CMD_DEL_POS;
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 255);
      else p = $urandom_range(1, model_len + 1);
      send_request(c, rand_value(), p);
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
